// ----- hdl/vaa_pkg.sv -----
// shared types, widths and constants for the vector angle pipeline
`timescale 1ns / 1ps

package vaa_pkg;

  // coordinate and angle port widths
  localparam int IN_W  = 16;
  localparam int ANG_W = 16;

  // fraction bits of the rotation datapath and the angle accumulator
  localparam int FRAC = 24;

  // x/y: 16-bit coordinate grown by sqrt(2) and the cordic gain, plus fraction and sign
  localparam int X_W = 44;
  // angle accumulator: |z| stays below 5 rad in Q.24
  localparam int Z_W = 29;

  // rounding of the Q.24 accumulator down to Q3.13
  localparam int RND_SH = FRAC - 13;

  // stage count default and table length
  localparam int STAGES_DEF = 16;
  localparam int ATAN_LEN   = 24;

  localparam logic signed [Z_W-1:0]   PI_Q24 = Z_W'(52707179);
  localparam logic signed [ANG_W-1:0] PI_Q13 = ANG_W'(25736);

  // round(atan(2^-i) * 2^24)
  localparam logic signed [Z_W-1:0] ATAN_Q24 [ATAN_LEN] = '{
    Z_W'(13176795), Z_W'(7778716), Z_W'(4110060), Z_W'(2086331),
    Z_W'(1047214),  Z_W'(524117),  Z_W'(262123),  Z_W'(131069),
    Z_W'(65536),    Z_W'(32768),   Z_W'(16384),   Z_W'(8192),
    Z_W'(4096),     Z_W'(2048),    Z_W'(1024),    Z_W'(512),
    Z_W'(256),      Z_W'(128),     Z_W'(64),      Z_W'(32),
    Z_W'(16),       Z_W'(8),       Z_W'(4),       Z_W'(2)
  };

  // one beat moving down the cell chain
  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
    logic                  on_axis;  // input y was zero
    logic                  x_neg;    // input x was negative
  } vaa_beat_t;

endpackage

// ----- hdl/vaa_prerot.sv -----
// entry cell: scales the coordinates and folds the left half-plane onto the right
`timescale 1ns / 1ps

module vaa_prerot import vaa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IN_W-1:0]  in_x,
  input  logic [IN_W-1:0]  in_y,
  output logic             out_valid,
  input  logic             out_ready,
  output vaa_beat_t        out_beat
);

  logic                  valid_r;
  vaa_beat_t             beat_r;
  vaa_beat_t             beat_nxt;
  logic signed [X_W-1:0] x_ext;
  logic signed [X_W-1:0] y_ext;

  // cell takes a beat when empty or when its neighbor takes the held one
  assign in_ready = !valid_r || out_ready;

  // sign extend and scale to Q.24
  assign x_ext = {{(X_W-IN_W-FRAC){in_x[IN_W-1]}}, in_x, {FRAC{1'b0}}};
  assign y_ext = {{(X_W-IN_W-FRAC){in_y[IN_W-1]}}, in_y, {FRAC{1'b0}}};

  // rotate by pi when x is negative
  always_comb begin
    beat_nxt.on_axis = (in_y == '0);
    beat_nxt.x_neg   = in_x[IN_W-1];
    if (in_x[IN_W-1]) begin
      beat_nxt.x = -x_ext;
      beat_nxt.y = -y_ext;
      beat_nxt.z = in_y[IN_W-1] ? -PI_Q24 : PI_Q24;
    end else begin
      beat_nxt.x = x_ext;
      beat_nxt.y = y_ext;
      beat_nxt.z = '0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

`ifndef SYNTHESIS
  // folded vector always lies in the right half-plane
  a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> !beat_r.x[X_W-1])
    else $error("prerot: negative x after fold");
`endif

endmodule

// ----- hdl/vaa_cell.sv -----
// one cordic micro-rotation cell of the vectoring chain
`timescale 1ns / 1ps

module vaa_cell import vaa_pkg::*; #(
  parameter int STAGE_IDX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  vaa_beat_t in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output vaa_beat_t out_beat
);

  logic                  valid_r;
  vaa_beat_t             beat_r;
  vaa_beat_t             beat_nxt;
  logic signed [X_W-1:0] x_c;
  logic signed [X_W-1:0] y_c;
  logic signed [X_W-1:0] xs;
  logic signed [X_W-1:0] ys;
  logic signed [Z_W-1:0] z_c;

  assign in_ready = !valid_r || out_ready;

  assign x_c = in_beat.x;
  assign y_c = in_beat.y;
  assign z_c = in_beat.z;
  assign xs  = x_c >>> STAGE_IDX;
  assign ys  = y_c >>> STAGE_IDX;

  // rotate toward the x axis by atan(2^-i)
  always_comb begin
    beat_nxt = in_beat;
    if (!y_c[X_W-1]) begin
      beat_nxt.x = x_c + ys;
      beat_nxt.y = y_c - xs;
      beat_nxt.z = z_c + ATAN_Q24[STAGE_IDX];
    end else begin
      beat_nxt.x = x_c - ys;
      beat_nxt.y = y_c + xs;
      beat_nxt.z = z_c - ATAN_Q24[STAGE_IDX];
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

// ----- hdl/vaa_round.sv -----
// exit cell: rounds the accumulated angle to Q3.13 and applies the axis cases
`timescale 1ns / 1ps

module vaa_round import vaa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  vaa_beat_t        in_beat,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ANG_W-1:0] out_angle
);

  localparam int Q_W = Z_W + 1 - RND_SH;

  logic                    valid_r;
  logic signed [ANG_W-1:0] angle_r;
  logic signed [ANG_W-1:0] angle_nxt;
  logic signed [Z_W:0]     z_bias;
  logic signed [Q_W-1:0]   q;
  logic signed [Q_W-1:0]   pi_pos;
  logic signed [Q_W-1:0]   pi_neg;

  assign in_ready = !valid_r || out_ready;

  // round half up, then floor shift
  assign z_bias = {in_beat.z[Z_W-1], in_beat.z} + (Z_W+1)'(1 << (RND_SH - 1));
  assign q      = Q_W'(z_bias >>> RND_SH);
  assign pi_pos = {{(Q_W-ANG_W){1'b0}}, PI_Q13};
  assign pi_neg = -pi_pos;

  // saturate to +-pi, axis cases bypass the rotation result
  always_comb begin
    if (in_beat.on_axis) begin
      angle_nxt = in_beat.x_neg ? PI_Q13 : '0;
    end else if (q > pi_pos) begin
      angle_nxt = PI_Q13;
    end else if (q < pi_neg) begin
      angle_nxt = -PI_Q13;
    end else begin
      angle_nxt = q[ANG_W-1:0];
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_angle = angle_r;

`ifndef SYNTHESIS
  // delivered angle never leaves [-pi, pi]
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (angle_r <= PI_Q13) && (angle_r >= -PI_Q13))
    else $error("round: angle out of range");
`endif

endmodule

// ----- hdl/vector_angle_atan2.sv -----
// top level: four-quadrant atan2 as a chain of cordic cells
//
//   channel  direction  ports                          beat
//   in_      input      in_valid/in_ready              in_x_coord, in_y_coord (s16)
//   out_     output     out_valid/out_ready            out_angle (s16, Q3.13 rad)
//
// one beat accepted per cycle unless a stall at out_ready has filled the chain, one result per beat, in order
// a beat passes the entry cell, one cell per micro-rotation, then the exit cell
// reset clears only the per-cell valid flags; the chain is empty after reset
// each cell holds one beat and takes a new one when empty or when its neighbor
// takes the held one, so a stall at out_ready fills the chain cell by cell
// and bubbles close up
`timescale 1ns / 1ps

module vector_angle_atan2 import vaa_pkg::*; #(
  parameter int CORDIC_STAGES = STAGES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IN_W-1:0]  in_x_coord,
  input  logic [IN_W-1:0]  in_y_coord,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ANG_W-1:0] out_angle
);

  vaa_beat_t chain_beat  [CORDIC_STAGES+1];
  logic      chain_valid [CORDIC_STAGES+1];
  logic      chain_ready [CORDIC_STAGES+1];

  // entry cell
  vaa_prerot u_prerot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x      (in_x_coord),
    .in_y      (in_y_coord),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_beat  (chain_beat[0])
  );

  // micro-rotation cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    vaa_cell #(
      .STAGE_IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_beat   (chain_beat[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_beat  (chain_beat[i+1])
    );
  end

  // exit cell
  vaa_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_valid[CORDIC_STAGES]),
    .in_ready  (chain_ready[CORDIC_STAGES]),
    .in_beat   (chain_beat[CORDIC_STAGES]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_angle (out_angle)
  );

`ifndef SYNTHESIS
  // input can only be held off by a result waiting at the output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("top: input stalled with output free");

  // a held result at the output keeps the last micro-rotation cell from draining into it
  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !chain_ready[CORDIC_STAGES] || !chain_valid[CORDIC_STAGES]
      || !out_valid)
    else $error("top: exit cell overwritten while held");
`endif

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the cordic atan2 pipeline
`timescale 1ns / 1ps

module testbench;
  import vaa_pkg::*;

  localparam int STAGES    = STAGES_DEF;
  localparam int N_RANDOM  = 800;
  localparam int MAX_CYC   = 400000;
  localparam int HOLD_CYC  = 300;
  localparam int N_DIRECT  = 18;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [IN_W-1:0]  in_x_coord;
  logic [IN_W-1:0]  in_y_coord;
  logic             out_valid;
  logic             out_ready;
  logic [ANG_W-1:0] out_angle;

  // one directed vector, with the angle typed in where it is obvious
  typedef struct packed {
    logic [IN_W-1:0]  x;
    logic [IN_W-1:0]  y;
    logic             known;
    logic [ANG_W-1:0] angle;
  } vec_row_t;

  // one outstanding angle and the vector that caused it
  typedef struct packed {
    logic [IN_W-1:0]  x;
    logic [IN_W-1:0]  y;
    logic [ANG_W-1:0] angle;
  } angle_exp_t;

  angle_exp_t pending_angles[$];

  int  mismatches;
  int  beats_in;
  int  beats_out;
  int  full_cycles;
  int  cycles;
  bit  steady;
  bit  hold_req;

  vec_row_t dir_rows [N_DIRECT] = '{
    '{16'h0000, 16'h0000, 1'b1, 16'h0000},  // zero vector
    '{16'h0001, 16'h0000, 1'b1, 16'h0000},  // positive x axis
    '{16'h7FFF, 16'h0000, 1'b1, 16'h0000},
    '{16'hFFFF, 16'h0000, 1'b1, PI_Q13},    // negative x axis
    '{16'h8000, 16'h0000, 1'b1, PI_Q13},
    '{16'h0000, 16'h0001, 1'b0, 16'h0000},
    '{16'h0000, 16'hFFFF, 1'b0, 16'h0000},
    '{16'h0000, 16'h7FFF, 1'b0, 16'h0000},
    '{16'h0000, 16'h8000, 1'b0, 16'h0000},
    '{16'h8000, 16'h8000, 1'b0, 16'h0000},
    '{16'h8000, 16'h7FFF, 1'b0, 16'h0000},
    '{16'h7FFF, 16'h7FFF, 1'b0, 16'h0000},
    '{16'h7FFF, 16'h8000, 1'b0, 16'h0000},
    '{16'h8000, 16'hFFFF, 1'b0, 16'h0000},  // just above -pi side
    '{16'h8000, 16'h0001, 1'b0, 16'h0000},  // just below +pi side
    '{16'hFFFF, 16'h0001, 1'b0, 16'h0000},
    '{16'h5555, 16'hAAAA, 1'b0, 16'h0000},
    '{16'hAAAA, 16'h5555, 1'b0, 16'h0000}
  };

  vector_angle_atan2 #(.CORDIC_STAGES(STAGES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x_coord(in_x_coord),
    .in_y_coord(in_y_coord),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_angle (out_angle)
  );

  // vectoring cordic in 64-bit Q.24, rounded half up to Q3.13 and clamped to +-pi
  function automatic logic [ANG_W-1:0] atan2_q13(input logic signed [IN_W-1:0] xc,
                                                 input logic signed [IN_W-1:0] yc);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint q;
    if (yc == 0) return (xc < 0) ? PI_Q13 : '0;
    x = longint'(xc) * (longint'(1) << FRAC);
    y = longint'(yc) * (longint'(1) << FRAC);
    z = 0;
    // left half plane: rotate by pi first
    if (x < 0) begin
      x = -x;
      y = -y;
      z = (yc >= 0) ? longint'(PI_Q24) : -longint'(PI_Q24);
    end
    for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_Q24[i]);
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_Q24[i]);
      end
    end
    q = (z + (longint'(1) << (RND_SH - 1))) >>> RND_SH;
    if (q > longint'(PI_Q13)) q = longint'(PI_Q13);
    if (q < -longint'(PI_Q13)) q = -longint'(PI_Q13);
    return ANG_W'(q);
  endfunction

  // offer one beat at the falling edge and hold it until the handshake
  task automatic offer_vector(input logic [IN_W-1:0] xv, input logic [IN_W-1:0] yv,
                              input logic [ANG_W-1:0] want);
    angle_exp_t e;
    in_valid   = 1'b1;
    in_x_coord = xv;
    in_y_coord = yv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e.x = xv;
    e.y = yv;
    e.angle = want;
    pending_angles.push_back(e);
    beats_in++;
    @(negedge clk);
    // random sender gaps, each cycle idle with 29 percent odds, none in the steady stretch
    if (!steady) begin
      while ($urandom_range(99) < 29) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
  endtask

  // random vector, biased toward axes, extremes and the pi seam
  task automatic pick_vector(output logic [IN_W-1:0] xv, output logic [IN_W-1:0] yv);
    int kind;
    int a;
    kind = $urandom_range(99);
    if (kind < 40) begin
      xv = IN_W'($urandom);
      yv = IN_W'($urandom);
    end else if (kind < 55) begin
      xv = IN_W'(int'($urandom_range(0, 16)) - 8);
      yv = IN_W'(int'($urandom_range(0, 16)) - 8);
    end else if (kind < 70) begin
      xv = IN_W'(-int'($urandom_range(1, 32768)));
      yv = IN_W'(int'($urandom_range(0, 6)) - 3);
    end else if (kind < 80) begin
      xv = IN_W'($urandom);
      yv = IN_W'($urandom);
      if ($urandom_range(1)) xv = '0;
      else yv = '0;
    end else if (kind < 90) begin
      case ($urandom_range(4))
        0: xv = 16'h8000;
        1: xv = 16'hFFFF;
        2: xv = 16'h0000;
        3: xv = 16'h0001;
        default: xv = 16'h7FFF;
      endcase
      case ($urandom_range(4))
        0: yv = 16'h8000;
        1: yv = 16'hFFFF;
        2: yv = 16'h0000;
        3: yv = 16'h0001;
        default: yv = 16'h7FFF;
      endcase
    end else begin
      a = $urandom_range(1, 32767);
      xv = IN_W'($urandom_range(1) ? a : -a);
      yv = IN_W'($urandom_range(1) ? a : -a);
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = steady ? 1'b1 : ($urandom_range(99) >= 29);
    end
  end

  // check each result beat against the oldest pending angle
  always @(posedge clk) begin
    cycles++;
    if (rst_n && in_valid && !in_ready) full_cycles++;
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (pending_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: angle=%0d", $signed(out_angle));
      end else begin
        angle_exp_t e;
        e = pending_angles.pop_front();
        if (out_angle !== e.angle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("angle mismatch x=%0d y=%0d: expected %0d, got %0d",
                     $signed(e.x), $signed(e.y), $signed(e.angle), $signed(out_angle));
        end
      end
    end
    if (cycles > MAX_CYC) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL vector_angle_atan2");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [IN_W-1:0] xv;
    logic [IN_W-1:0] yv;
    mismatches  = 0;
    beats_in    = 0;
    beats_out   = 0;
    full_cycles = 0;
    cycles      = 0;
    steady      = 1'b0;
    hold_req    = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_x_coord  = '0;
    in_y_coord  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed vectors
    foreach (dir_rows[i])
      offer_vector(dir_rows[i].x, dir_rows[i].y,
                   dir_rows[i].known ? dir_rows[i].angle
                                     : atan2_q13(dir_rows[i].x, dir_rows[i].y));

    // random vectors, with a steady stretch, a long hold-off and a full drain
    for (int n = 0; n < N_RANDOM; n++) begin
      steady = (n >= 250 && n < 400);
      if (n == 500) hold_req = 1'b1;
      if (n == 650) begin
        in_valid = 1'b0;
        while (pending_angles.size() != 0) @(negedge clk);
      end
      pick_vector(xv, yv);
      offer_vector(xv, yv, atan2_q13(xv, yv));
    end
    in_valid = 1'b0;
    steady   = 1'b0;

    // drain, then let the chain run empty
    while (pending_angles.size() != 0) @(negedge clk);
    repeat (STAGES + 10) @(negedge clk);

    $display("%0d vectors in, %0d angles out; axes, extremes, pi seam and diagonals covered",
             beats_in, beats_out);
    $display("input stalled %0d cycles by back-pressure, %0d mismatches",
             full_cycles, mismatches);
    if (mismatches == 0) begin
      $display("PASS vector_angle_atan2");
    end else begin
      $display("FAIL vector_angle_atan2");
    end
    $finish;
  end

endmodule
